// ----- hw/rtl/ppt_pkg.sv -----
// ----------------------------------------------------------------------------
// ppt_pkg: shared types for the pocket perceptron trainer
// Beat payloads, sample record, opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ppt_pkg;

  // operation codes of an input beat
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_TRAIN = 1'b1
  } ppt_op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_EPOCH_LIMIT = 2'd0,
    CFG_INIT_BIAS   = 2'd1,
    CFG_INIT_W1     = 2'd2,
    CFG_INIT_W2     = 2'd3
  } ppt_cfg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } ppt_state_e;

  // kind of pass over the stored samples
  typedef enum logic [1:0] {
    PASS_INIT,
    PASS_TRAIN,
    PASS_CHECK
  } ppt_pass_e;

  // input beat
  typedef struct packed {
    logic               operation;
    logic signed [15:0] feature_one;
    logic signed [15:0] feature_two;
    logic               label_positive;
  } ppt_in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] bias_weight;
    logic signed [31:0] weight_one;
    logic signed [31:0] weight_two;
    logic [6:0]         error_count;
  } ppt_out_t;

  // one stored sample
  typedef struct packed {
    logic signed [15:0] f1;
    logic signed [15:0] f2;
    logic               pos;
  } ppt_sample_t;

  // reset values of the configuration registers
  localparam logic [15:0] EPOCH_LIMIT_RST = 16'd100;
  localparam logic [31:0] INIT_BIAS_RST   = 32'd0;
  localparam logic [31:0] INIT_W_RST      = 32'd4096;

  // saturation point of the reported error count
  localparam logic [6:0] ERR_CNT_MAX = 7'd127;

endpackage

// ----- hw/rtl/ppt_ram.sv -----
// ----------------------------------------------------------------------------
// ppt_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered, valid in the cycle after the address.
// ----------------------------------------------------------------------------
module ppt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ppt_eval.sv -----
// ----------------------------------------------------------------------------
// ppt_eval: score and update datapath
// Registers the two feature products, then forms the exact score sign and the
// saturated candidate weights for a misclassified sample.
// ----------------------------------------------------------------------------
module ppt_eval #(
  parameter int WEIGHT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           ld_i,
  input  ppt_pkg::ppt_sample_t           smp_i,
  input  logic signed [WEIGHT_WIDTH-1:0] w0_i,
  input  logic signed [WEIGHT_WIDTH-1:0] w1_i,
  input  logic signed [WEIGHT_WIDTH-1:0] w2_i,
  output logic                           mis_o,
  output logic signed [WEIGHT_WIDTH-1:0] w0_o,
  output logic signed [WEIGHT_WIDTH-1:0] w1_o,
  output logic signed [WEIGHT_WIDTH-1:0] w2_o
);

  localparam int W  = WEIGHT_WIDTH;
  localparam int PW = W + 16;
  localparam int SW = W + 18;

  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [15:0]   x1_q, x2_q;
  logic                 pos_q;

  logic signed [SW-1:0] t0, t1, t2, score;
  logic                 neg, zero;
  logic signed [W:0]    d0, d1, d2;

  // add with saturation to the weight range
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] w,
                                                  input logic signed [W:0]   d);
    logic signed [W:0] s;
    logic signed [W-1:0] r;
    s = {w[W-1], w} + d;
    if (s[W] != s[W-1]) begin
      r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // product stage
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      p1_q  <= PW'(w1_i) * PW'(smp_i.f1);
      p2_q  <= PW'(w2_i) * PW'(smp_i.f2);
      x1_q  <= smp_i.f1;
      x2_q  <= smp_i.f2;
      pos_q <= smp_i.pos;
    end
  end

  // exact score, only its sign matters
  always_comb begin
    t0    = {{6{w0_i[W-1]}}, w0_i, 12'b0};
    t1    = {{2{p1_q[PW-1]}}, p1_q};
    t2    = {{2{p2_q[PW-1]}}, p2_q};
    score = t0 + t1 + t2;
    neg   = score[SW-1];
    zero  = (score == '0);
    mis_o = pos_q ? neg : (!neg && !zero);
  end

  // candidate weights, moved toward the label
  always_comb begin
    d0 = pos_q ? (W+1)'(4096) : -(W+1)'(4096);
    d1 = {{(W-15){x1_q[15]}}, x1_q};
    d2 = {{(W-15){x2_q[15]}}, x2_q};
    if (!pos_q) begin
      d1 = -d1;
      d2 = -d2;
    end
    w0_o = sat_add(w0_i, d0);
    w1_o = sat_add(w1_i, d1);
    w2_o = sat_add(w2_i, d2);
  end

endmodule

// ----- hw/rtl/pocket_perceptron_trainer_top.sv -----
// ----------------------------------------------------------------------------
// pocket_perceptron_trainer_top: pocket perceptron trainer
// Stores labelled two-feature samples and trains a perceptron with a pocket.
// ----------------------------------------------------------------------------
// A store beat (operation 0) is written to the sample RAM; busy stays low and a
// new beat may follow at once. A train beat raises busy until its result strobe
// done_o; with no stored samples it goes straight to the done state. Each sample
// takes two steps in every pass (sample RAM read with product register, then
// score sum and weight update); a train run starts with an error counting pass,
// and every epoch is a training pass plus an error counting pass. done_o is high
// for exactly one cycle and the result cannot be held off, so the receiver must
// take it then.
module pocket_perceptron_trainer_top #(
  parameter int MAX_SAMPLES  = 64,
  parameter int WEIGHT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ppt_pkg::ppt_in_t  in_i,
  output logic              done_o,
  output ppt_pkg::ppt_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);

  localparam int W    = WEIGHT_WIDTH;
  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int CW   = ((W > 32) ? W : 32) + 1;
  localparam int SMPW = $bits(ppt_pkg::ppt_sample_t);

  localparam logic signed [CW-1:0] WMAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [CW-1:0] WMIN = ~WMAX;
  localparam logic signed [CW-1:0] OMAX = {{(CW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [CW-1:0] OMIN = ~OMAX;

  // configuration registers
  logic [15:0] epoch_limit_q;
  logic [31:0] init_bias_q, init_w1_q, init_w2_q;

  // sequencer state
  ppt_pkg::ppt_state_e state_q, state_d;
  ppt_pkg::ppt_pass_e  pass_q, pass_d;
  logic [CNTW-1:0]     idx_q, idx_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [CNTW-1:0]     err_q, err_d;
  logic [CNTW-1:0]     perr_q, perr_d;
  logic [15:0]         epoch_q, epoch_d;

  // working and pocket weights
  logic signed [W-1:0] w_q [3];
  logic signed [W-1:0] w_d [3];
  logic signed [W-1:0] pw_q [3];
  logic signed [W-1:0] pw_d [3];

  // memory and datapath links
  logic                 ram_we;
  logic [AW-1:0]        rd_addr;
  ppt_pkg::ppt_sample_t wr_smp, rd_smp;
  logic [SMPW-1:0]      rd_data;
  logic                 mis;
  logic signed [W-1:0]  w_upd [3];
  logic                 last;
  logic [CNTW-1:0]      err_fin;
  logic [CNTW+6:0]      perr_ext;

  // 32-bit init value saturated to the weight width
  function automatic logic signed [W-1:0] sat_w(input logic [31:0] v);
    logic signed [CW-1:0] e;
    logic signed [W-1:0]  r;
    e = {{(CW-32){v[31]}}, v};
    if (e > WMAX) begin
      r = WMAX[W-1:0];
    end else if (e < WMIN) begin
      r = WMIN[W-1:0];
    end else begin
      r = e[W-1:0];
    end
    return r;
  endfunction

  // weight saturated to the 32-bit result field
  function automatic logic signed [31:0] sat_o(input logic signed [W-1:0] v);
    logic signed [CW-1:0] e;
    logic signed [31:0]   r;
    e = {{(CW-W){v[W-1]}}, v};
    if (e > OMAX) begin
      r = OMAX[31:0];
    end else if (e < OMIN) begin
      r = OMIN[31:0];
    end else begin
      r = e[31:0];
    end
    return r;
  endfunction

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_limit_q <= ppt_pkg::EPOCH_LIMIT_RST;
      init_bias_q   <= ppt_pkg::INIT_BIAS_RST;
      init_w1_q     <= ppt_pkg::INIT_W_RST;
      init_w2_q     <= ppt_pkg::INIT_W_RST;
    end else if (cfg_we_i) begin
      case (ppt_pkg::ppt_cfg_e'(cfg_idx_i))
        ppt_pkg::CFG_EPOCH_LIMIT: epoch_limit_q <= cfg_wdata_i[15:0];
        ppt_pkg::CFG_INIT_BIAS:   init_bias_q   <= cfg_wdata_i;
        ppt_pkg::CFG_INIT_W1:     init_w1_q     <= cfg_wdata_i;
        ppt_pkg::CFG_INIT_W2:     init_w2_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sample store
  always_comb begin
    wr_smp.f1  = in_i.feature_one;
    wr_smp.f2  = in_i.feature_two;
    wr_smp.pos = in_i.label_positive;
  end

  ppt_ram #(
    .WIDTH (SMPW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wr_smp),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_smp = ppt_pkg::ppt_sample_t'(rd_data);

  ppt_eval #(
    .WEIGHT_WIDTH (W)
  ) u_eval (
    .clk_i (clk_i),
    .ld_i  (state_q == ppt_pkg::ST_MUL),
    .smp_i (rd_smp),
    .w0_i  (w_q[0]),
    .w1_i  (w_q[1]),
    .w2_i  (w_q[2]),
    .mis_o (mis),
    .w0_o  (w_upd[0]),
    .w1_o  (w_upd[1]),
    .w2_o  (w_upd[2])
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppt_pkg::ST_IDLE;
      pass_q  <= ppt_pkg::PASS_INIT;
      idx_q   <= '0;
      cnt_q   <= '0;
      err_q   <= '0;
      perr_q  <= '0;
      epoch_q <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      perr_q  <= perr_d;
      epoch_q <= epoch_d;
    end
  end

  // weight registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k]  <= '0;
        pw_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        w_q[k]  <= w_d[k];
        pw_q[k] <= pw_d[k];
      end
    end
  end

  assign last    = ((idx_q + CNTW'(1)) == cnt_q);
  assign err_fin = err_q + CNTW'(mis);

  // next state and outputs
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    perr_d  = perr_q;
    epoch_d = epoch_q;
    w_d     = w_q;
    pw_d    = pw_q;
    ram_we  = 1'b0;
    rd_addr = idx_q[AW-1:0];
    done_o  = 1'b0;

    case (state_q)
      ppt_pkg::ST_IDLE: begin
        if (start) begin
          if (in_i.operation == ppt_pkg::OP_TRAIN) begin
            w_d[0]  = sat_w(init_bias_q);
            w_d[1]  = sat_w(init_w1_q);
            w_d[2]  = sat_w(init_w2_q);
            pw_d    = w_d;
            idx_d   = '0;
            err_d   = '0;
            rd_addr = '0;
            if (cnt_q == '0) begin
              perr_d  = '0;
              state_d = ppt_pkg::ST_DONE;
            end else begin
              pass_d  = ppt_pkg::PASS_INIT;
              state_d = ppt_pkg::ST_MUL;
            end
          end else if (cnt_q != CNTW'(MAX_SAMPLES)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CNTW'(1);
          end
        end
      end

      ppt_pkg::ST_MUL: begin
        state_d = ppt_pkg::ST_ACC;
      end

      ppt_pkg::ST_ACC: begin
        err_d = err_fin;
        if ((pass_q == ppt_pkg::PASS_TRAIN) && mis) begin
          w_d = w_upd;
        end
        state_d = ppt_pkg::ST_MUL;
        if (!last) begin
          // fetch the next sample
          idx_d   = idx_q + CNTW'(1);
          rd_addr = idx_d[AW-1:0];
        end else begin
          // end of a pass, restart at the first sample
          idx_d   = '0;
          err_d   = '0;
          rd_addr = '0;
          case (pass_q)
            ppt_pkg::PASS_INIT: begin
              perr_d  = err_fin;
              epoch_d = '0;
              pass_d  = ppt_pkg::PASS_TRAIN;
              if (epoch_limit_q == '0) begin
                state_d = ppt_pkg::ST_DONE;
              end
            end
            ppt_pkg::PASS_TRAIN: begin
              pass_d = ppt_pkg::PASS_CHECK;
            end
            ppt_pkg::PASS_CHECK: begin
              if (err_fin < perr_q) begin
                pw_d   = w_q;
                perr_d = err_fin;
              end
              epoch_d = epoch_q + 16'd1;
              pass_d  = ppt_pkg::PASS_TRAIN;
              if (epoch_d == epoch_limit_q) begin
                state_d = ppt_pkg::ST_DONE;
              end
            end
            default: begin
              state_d = ppt_pkg::ST_IDLE;
            end
          endcase
        end
      end

      ppt_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = ppt_pkg::ST_IDLE;
      end

      default: begin
        state_d = ppt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ppt_pkg::ST_IDLE);

  // result beat from the pocket copy
  always_comb begin
    perr_ext              = {7'b0, perr_q};
    result_o.bias_weight  = sat_o(pw_q[0]);
    result_o.weight_one   = sat_o(pw_q[1]);
    result_o.weight_two   = sat_o(pw_q[2]);
    result_o.error_count  = (perr_ext > (CNTW+7)'(ppt_pkg::ERR_CNT_MAX)) ?
                            ppt_pkg::ERR_CNT_MAX : perr_ext[6:0];
  end

endmodule
